/* rtl/core/sbusdec_pkg.sv */
// Shared types, constants and frame layout for the SBUS frame decoder.
`default_nettype none
package sbusdec_pkg;

  // Frame layout.
  localparam int unsigned FrameLen  = 25;
  localparam int unsigned StoreLen  = 24;
  localparam int unsigned DataBytes = 22;
  localparam int unsigned NumChan   = 16;
  localparam int unsigned ChanW     = 11;
  localparam int unsigned DataW     = DataBytes * 8;

  localparam logic [7:0] HeaderA  = 8'h0F;
  localparam logic [7:0] HeaderB  = 8'h8F;
  localparam logic [7:0] FooterA  = 8'h00;
  localparam logic [7:0] FooterB  = 8'h08;
  localparam logic [7:0] FlagMask = 8'h0C;

  // Scaling arithmetic: num = 1000 * (raw + max - 2 * min), at most 22 bits.
  localparam int unsigned ScaleK  = 1000;
  localparam int unsigned ScaleKW = 10;
  localparam int unsigned DiffW   = ChanW + 1;
  localparam int unsigned NumW    = DiffW + ScaleKW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = ChanW;
  localparam logic [CfgIdxW-1:0] CfgRawMin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRawMax = 2'd1;
  localparam logic [ChanW-1:0] RawMinReset = 11'd172;
  localparam logic [ChanW-1:0] RawMaxReset = 11'd1811;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFrameErr = 2'd1,
    StatusNoSignal = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;
  } out_t;

  // One checked frame handed from the front to the back.
  typedef struct packed {
    status_e          kind;
    logic [DataW-1:0] data;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage
`default_nettype wire

/* rtl/core/sbusdec_front.sv */
// Front end: byte counting, frame buffering and frame checking.
`default_nettype none
module sbusdec_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire sbusdec_pkg::in_t           in_i,
  input  wire sbusdec_pkg::queue_status_t q_status_i,
  output logic                            push_o,
  output sbusdec_pkg::job_t               job_o
);
  import sbusdec_pkg::*;

  logic [4:0] cnt_q, cnt_d;
  logic [4:0] cnt_cur;
  logic [7:0] store_q [StoreLen];
  logic       accept;
  logic       head_ok, foot_ok;

  // Every byte is held off while the frame queue is full.
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_cur    = in_i.frame_start ? 5'd0 : cnt_q;

  always_comb begin
    cnt_d  = cnt_q;
    push_o = 1'b0;
    if (accept) begin
      if (cnt_cur < 5'(StoreLen)) begin
        cnt_d = cnt_cur + 5'd1;
      end else if (cnt_cur == 5'(StoreLen)) begin
        cnt_d  = 5'(FrameLen);
        push_o = 1'b1;
      end else begin
        cnt_d = cnt_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'(FrameLen);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_cur < 5'(StoreLen)) begin
      store_q[cnt_cur] <= in_i.data_byte;
    end
  end

  assign head_ok = store_q[0] == HeaderA || store_q[0] == HeaderB;
  assign foot_ok = in_i.data_byte == FooterA || in_i.data_byte == FooterB;

  always_comb begin
    for (int i = 0; i < DataBytes; i++) begin
      job_o.data[i*8 +: 8] = store_q[i+1];
    end
    if (!head_ok || !foot_ok) begin
      job_o.kind = StatusFrameErr;
    end else if ((store_q[StoreLen-1] & FlagMask) != 8'd0) begin
      job_o.kind = StatusNoSignal;
    end else begin
      job_o.kind = StatusOk;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sbusdec_queue.sv */
// Small queue of checked frames between the front and back ends.
`default_nettype none
module sbusdec_queue #(
  parameter int unsigned Depth = sbusdec_pkg::QueueDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sbusdec_pkg::job_t     job_i,
  input  wire logic                  pop_i,
  output sbusdec_pkg::job_t          head_o,
  output sbusdec_pkg::queue_status_t status_o
);
  import sbusdec_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign head_o          = mem_q[rd_q];
  assign status_o.empty  = cnt_q == '0;
  assign status_o.full   = cnt_q == CntW'(Depth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sbusdec_back.sv */
// Back end: channel unpacking, iterative scaling divide and result register.
`default_nettype none
module sbusdec_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sbusdec_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbusdec_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire sbusdec_pkg::job_t               head_i,
  input  wire sbusdec_pkg::queue_status_t      q_status_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output sbusdec_pkg::out_t                    out_o
);
  import sbusdec_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;
  localparam int unsigned DivCntW = $clog2(NumW);

  logic [1:0]         state_q, state_d;
  logic [ChanW-1:0]   raw_min_q, raw_max_q;
  logic [DataW-1:0]   shift_q, shift_d;
  logic [3:0]         ch_q, ch_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [NumW-1:0]    quot_q, quot_d;
  logic [ChanW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic [ChanW-1:0]   raw;
  logic [ChanW-1:0]   span;
  logic [DiffW-1:0]   sum, two_min;
  logic [ChanW:0]     rem_shift;
  logic               slot_free;
  logic               last;
  logic [15:0]        sat_value;

  assign raw       = shift_q[ChanW-1:0];
  assign span      = raw_max_q - raw_min_q;
  assign sum       = {1'b0, raw} + {1'b0, raw_max_q};
  assign two_min   = {raw_min_q, 1'b0};
  assign rem_shift = {rem_q, num_q[NumW-1]};
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last      = head_i.kind != StatusOk || ch_q == 4'(NumChan - 1);
  assign sat_value = (|quot_q[NumW-1:16]) ? 16'hFFFF : quot_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_min_q <= RawMinReset;
      raw_max_q <= RawMaxReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgRawMin) begin
        raw_min_q <= cfg_wdata_i;
      end else if (cfg_index_i == CfgRawMax) begin
        raw_max_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    ch_d        = ch_q;
    num_d       = num_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_status_i.empty) begin
          ch_d   = 4'd0;
          quot_d = '0;
          if (head_i.kind == StatusOk) begin
            shift_d = head_i.data;
            state_d = StPrep;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StPrep: begin
        // An empty range or a value below the scaled zero gives zero directly.
        if (raw_max_q <= raw_min_q || sum < two_min) begin
          quot_d  = '0;
          state_d = StEmit;
        end else begin
          num_d     = NumW'(sum - two_min) * NumW'(ScaleK);
          quot_d    = '0;
          rem_d     = '0;
          div_cnt_d = DivCntW'(NumW - 1);
          state_d   = StDiv;
        end
      end
      StDiv: begin
        // Restoring division, one quotient bit per cycle.
        num_d = {num_q[NumW-2:0], 1'b0};
        if (rem_shift >= {1'b0, span}) begin
          rem_d  = ChanW'(rem_shift - {1'b0, span});
          quot_d = {quot_q[NumW-2:0], 1'b1};
        end else begin
          rem_d  = rem_shift[ChanW-1:0];
          quot_d = {quot_q[NumW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q - DivCntW'(1);
        if (div_cnt_q == '0) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = head_i.kind;
          out_d.channel_index = ch_q;
          out_d.channel_value = sat_value;
          out_d.last          = last;
          if (last) begin
            pop_o   = 1'b1;
            state_d = StIdle;
          end else begin
            ch_d    = ch_q + 4'd1;
            shift_d = shift_q >> ChanW;
            state_d = StPrep;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    ch_q      <= ch_d;
    num_q     <= num_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

/* rtl/core/sbus_frame_decoder_core.sv */
// Top level of the SBUS frame decoder: front end, frame queue and back end.
//
// The decoder takes a receiver stream one byte per transaction. A byte with
// frame_start set begins a frame; the first 24 bytes are buffered and the
// 25th closes the frame. The front end then checks header, footer and the
// lost-signal flags and queues the frame, so it keeps taking bytes of the
// next frame while the back end still works. The back end gives one
// frame-error or one no-signal result, or sixteen channel results, each
// scaled so that raw_min maps to 1000 and raw_max to 2000, saturated to 16
// bits; the last result of a frame has last set. Bytes after the 25th, and
// bytes before the first frame start, are dropped without a result.
//
// Rate: a byte transaction is accepted every cycle unless the frame queue
// is full. For each channel of a good frame the back end takes a setup
// step, the restoring divider with one quotient bit per cycle, and a step
// that loads the result register, which waits while the output stalls.
// Error and no-signal frames skip the setup and the divider. The divider
// is the limiting unit.
//
// The user writes the raw_min, raw_max registers via the plain write port
// only while idle, not enforced by the block; indexes above 1 are ignored.
`default_nettype none
module sbus_frame_decoder_core #(
  parameter int unsigned QueueDepth = sbusdec_pkg::QueueDepthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire sbusdec_pkg::in_t                 in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output sbusdec_pkg::out_t                     out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [sbusdec_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbusdec_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sbusdec_pkg::*;

  // Checked frames travel from the front end to the back end through the
  // queue; the front only stalls its input when the queue is full.
  logic          push, pop;
  job_t          job_in, job_head;
  queue_status_t q_status;

  sbusdec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_in)
  );

  sbusdec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .head_o   (job_head),
    .status_o (q_status)
  );

  // The back end holds the scaling registers and the output register, so a
  // finished result can wait for the consumer while the front keeps going.
  sbusdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (job_head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire
